>>> rtl/overflow_policy_fifo_macros.svh
// Assertion macros for the overflow policy FIFO.
// Used by the top level only; needs a clock and an active-low reset.
`ifndef OVERFLOW_POLICY_FIFO_MACROS_SVH
`define OVERFLOW_POLICY_FIFO_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define OFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ofp_pkg.sv
// Shared codes, selector constants and controller/datapath interface types
// for the overflow policy FIFO. No dependencies.
package ofp_pkg;

    localparam int TAG_W     = 16;
    localparam int STATUS_W  = 3;
    localparam int POLICY_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int LFSR_W    = 16;

    localparam logic [LFSR_W-1:0] LFSR_MASK  = 16'hB400;
    localparam logic [LFSR_W-1:0] LFSR_RESET = 16'h0001;

    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DEQUEUED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd5;

    localparam logic [POLICY_W-1:0] POL_BLOCK  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_DROP   = 2'd1;
    localparam logic [POLICY_W-1:0] POL_HEAD   = 2'd2;
    localparam logic [POLICY_W-1:0] POL_RANDOM = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd1;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // read address select
    localparam logic [1:0] RA_HEAD = 2'd0;
    localparam logic [1:0] RA_POS  = 2'd1;
    localparam logic [1:0] RA_NEXT = 2'd2;

    // write address select
    localparam logic WA_TAIL = 1'b0;
    localparam logic WA_POS  = 1'b1;

    // result tag select
    localparam logic [1:0] TAG_ZERO  = 2'd0;
    localparam logic [1:0] TAG_VAL   = 2'd1;
    localparam logic [1:0] TAG_RDATA = 2'd2;
    localparam logic [1:0] TAG_HOLD  = 2'd3;

    // result occupancy select
    localparam logic [1:0] OCC_SAME = 2'd0;
    localparam logic [1:0] OCC_INC  = 2'd1;
    localparam logic [1:0] OCC_DEC  = 2'd2;

    typedef struct packed {
        logic                latch_in;
        logic                rd_en;
        logic [1:0]          ra_sel;
        logic                wr_en;
        logic                wa_sel;
        logic                emit;
        logic [STATUS_W-1:0] emit_status;
        logic [1:0]          tag_sel;
        logic [1:0]          occ_sel;
        logic                emit_last;
        logic                head_inc;
        logic                cnt_inc;
        logic                cnt_dec;
        logic                lfsr_adv;
        logic                rem_start;
        logic                pos_load;
        logic                pos_inc;
        logic                evict_load;
        logic                evict_dec;
        logic                tag_hold;
    } t_cmd;

    typedef struct packed {
        logic                op;
        logic                empty;
        logic                full;
        logic [POLICY_W-1:0] policy;
        logic                out_free;
        logic                rem_done;
        logic                shift_more;
        logic                evict_last;
    } t_stat;

endpackage

>>> rtl/overflow_policy_fifo.sv
// Overflow policy FIFO top level: sequencer plus datapath.
// Depends on ofp_pkg, ofp_ctrl, ofp_dp and overflow_policy_fifo_macros.svh.
//
// Usage: items enter on i_in_valid/o_in_ready (i_operation: 0 push
// i_entry_value, 1 pop). Each item yields one to CAPACITY/4+1 results on
// o_out_valid/i_out_ready; o_last marks the final result of an item.
// Config writes (i_cfg_*) are always ready: index 0 sets the full-ring
// policy, index 1 loads the LFSR seed (zero loads as one). Write only
// while no item is in flight.
// An empty pop or a full-ring reject or drop is answered from the decode
// state, a push is written and answered from the append state, a pop reads
// the head and then emits, and a drop-head push pops the head, then appends.
// One item is worked on at a time. Each random-drop eviction advances the
// LFSR, runs the 16-step remainder unit, reads and holds the chosen entry,
// then moves each later entry down one slot (read, then write) and emits.
// Reset (synchronous, active low) empties the ring, sets policy to block
// and seeds the LFSR with one; ring contents are not cleared.
// A stalled receiver holds the result register; the block waits for it,
// but a new item is taken as soon as the previous item's work is done.
`include "overflow_policy_fifo_macros.svh"

module overflow_policy_fifo
    import ofp_pkg::*;
#(
    parameter  int CAPACITY = 16,
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_operation,
    input  logic [TAG_W-1:0]     i_entry_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [TAG_W-1:0]     o_tag_out,
    output logic [CW-1:0]        o_occupancy,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    ofp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ofp_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_operation   (i_operation),
        .i_entry_value (i_entry_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_tag_out     (o_tag_out),
        .o_occupancy   (o_occupancy),
        .o_last        (o_last),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat)
    );

    `OFP_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, w_cmd.emit, w_stat.out_free, "result overwritten")
    `OFP_ASSERT_NOW(a_idle_quiet, i_clk, i_rst_n, o_in_ready, !w_cmd.emit && !w_cmd.wr_en, "busy while idle")
    `OFP_ASSERT_NOW(a_occ_bound, i_clk, i_rst_n, o_out_valid, o_occupancy <= CW'(CAPACITY), "occupancy overflow")
    `OFP_ASSERT_NOW(a_evict_not_last, i_clk, i_rst_n, o_out_valid && o_status == ST_EVICTED, !o_last, "eviction marked last")
    `OFP_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "second item taken")

endmodule

>>> rtl/ofp_rem.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
// Uses ofp_pkg for the dividend width.
module ofp_rem
    import ofp_pkg::*;
#(
    parameter int VW = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [LFSR_W-1:0] i_dividend,
    input  logic [VW-1:0]     i_divisor,
    output logic              o_done,
    output logic [VW-1:0]     o_rem
);

    localparam int SW = $clog2(LFSR_W);

    logic              r_busy;
    logic              r_done;
    logic [SW-1:0]     r_step;
    logic [LFSR_W-1:0] r_dvd;
    logic [VW-1:0]     r_rem;
    logic [VW:0]       w_trial;
    logic [VW-1:0]     n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[LFSR_W-1]};
        if (w_trial >= {1'b0, i_divisor}) begin
            n_rem = VW'(w_trial - {1'b0, i_divisor});
        end else begin
            n_rem = w_trial[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == SW'(LFSR_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_dvd  <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_step <= r_step + SW'(1);
            r_dvd  <= {r_dvd[LFSR_W-2:0], 1'b0};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/ofp_ctrl.sv
// Sequencer for the overflow policy FIFO: decodes each item and steps the
// datapath through pops, appends and random evictions. Uses ofp_pkg.
module ofp_ctrl
    import ofp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECIDE   = 4'd1;
    localparam logic [3:0] S_POP_RD   = 4'd2;
    localparam logic [3:0] S_POP_EMIT = 4'd3;
    localparam logic [3:0] S_APPEND   = 4'd4;
    localparam logic [3:0] S_R_ADV    = 4'd5;
    localparam logic [3:0] S_R_START  = 4'd6;
    localparam logic [3:0] S_R_WAIT   = 4'd7;
    localparam logic [3:0] S_R_RD     = 4'd8;
    localparam logic [3:0] S_R_HOLD   = 4'd9;
    localparam logic [3:0] S_SH_RD    = 4'd10;
    localparam logic [3:0] S_SH_WR    = 4'd11;
    localparam logic [3:0] S_R_EMIT   = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.latch_in = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.op == OP_DEQ) begin
                    if (!i_stat.empty) begin
                        n_state = S_POP_RD;
                    end else if (i_stat.out_free) begin
                        w_cmd.emit        = 1'b1;
                        w_cmd.emit_status = ST_EMPTY;
                        w_cmd.emit_last   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else if (!i_stat.full) begin
                    n_state = S_APPEND;
                end else begin
                    unique case (i_stat.policy) inside
                        POL_BLOCK, POL_DROP: begin
                            if (i_stat.out_free) begin
                                w_cmd.emit        = 1'b1;
                                w_cmd.emit_last   = 1'b1;
                                w_cmd.emit_status = (i_stat.policy == POL_BLOCK) ?
                                                    ST_FULL : ST_DROPPED;
                                w_cmd.tag_sel     = (i_stat.policy == POL_BLOCK) ?
                                                    TAG_ZERO : TAG_VAL;
                                n_state           = S_IDLE;
                            end
                        end
                        POL_HEAD: begin
                            n_state = S_POP_RD;
                        end
                        default: begin
                            w_cmd.evict_load = 1'b1;
                            n_state          = S_R_ADV;
                        end
                    endcase
                end
            end
            S_POP_RD: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.ra_sel = RA_HEAD;
                n_state      = S_POP_EMIT;
            end
            S_POP_EMIT: begin
                if (i_stat.out_free) begin
                    w_cmd.emit        = 1'b1;
                    w_cmd.emit_status = (i_stat.op == OP_DEQ) ? ST_DEQUEUED : ST_EVICTED;
                    w_cmd.emit_last   = (i_stat.op == OP_DEQ);
                    w_cmd.tag_sel     = TAG_RDATA;
                    w_cmd.occ_sel     = OCC_DEC;
                    w_cmd.head_inc    = 1'b1;
                    w_cmd.cnt_dec     = 1'b1;
                    n_state           = (i_stat.op == OP_DEQ) ? S_IDLE : S_APPEND;
                end
            end
            S_APPEND: begin
                if (i_stat.out_free) begin
                    w_cmd.wr_en       = 1'b1;
                    w_cmd.wa_sel      = WA_TAIL;
                    w_cmd.cnt_inc     = 1'b1;
                    w_cmd.emit        = 1'b1;
                    w_cmd.emit_status = ST_ACCEPTED;
                    w_cmd.occ_sel     = OCC_INC;
                    w_cmd.emit_last   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_R_ADV: begin
                w_cmd.lfsr_adv = 1'b1;
                n_state        = S_R_START;
            end
            S_R_START: begin
                w_cmd.rem_start = 1'b1;
                n_state         = S_R_WAIT;
            end
            S_R_WAIT: begin
                if (i_stat.rem_done) begin
                    w_cmd.pos_load = 1'b1;
                    n_state        = S_R_RD;
                end
            end
            S_R_RD: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.ra_sel = RA_POS;
                n_state      = S_R_HOLD;
            end
            S_R_HOLD: begin
                w_cmd.tag_hold = 1'b1;
                n_state        = S_SH_RD;
            end
            S_SH_RD: begin
                if (i_stat.shift_more) begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.ra_sel = RA_NEXT;
                    n_state      = S_SH_WR;
                end else begin
                    n_state = S_R_EMIT;
                end
            end
            S_SH_WR: begin
                w_cmd.wr_en   = 1'b1;
                w_cmd.wa_sel  = WA_POS;
                w_cmd.pos_inc = 1'b1;
                n_state       = S_SH_RD;
            end
            S_R_EMIT: begin
                if (i_stat.out_free) begin
                    w_cmd.emit        = 1'b1;
                    w_cmd.emit_status = ST_EVICTED;
                    w_cmd.tag_sel     = TAG_HOLD;
                    w_cmd.occ_sel     = OCC_DEC;
                    w_cmd.cnt_dec     = 1'b1;
                    w_cmd.evict_dec   = 1'b1;
                    n_state           = i_stat.evict_last ? S_APPEND : S_R_ADV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

endmodule

>>> rtl/ofp_dp.sv
// Datapath for the overflow policy FIFO: tag ring memory, head and count,
// LFSR, config registers, eviction cursor and the result register.
// Uses ofp_pkg and ofp_rem.
module ofp_dp
    import ofp_pkg::*;
#(
    parameter  int CAPACITY = 16,
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_operation,
    input  logic [TAG_W-1:0]     i_entry_value,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STATUS_W-1:0]  o_status,
    output logic [TAG_W-1:0]     o_tag_out,
    output logic [CW-1:0]        o_occupancy,
    output logic                 o_last,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat
);

    localparam int IW = $clog2(CAPACITY);

    logic [TAG_W-1:0]    r_mem [CAPACITY];
    logic [TAG_W-1:0]    r_rdata;
    logic [IW-1:0]       r_head;
    logic [CW-1:0]       r_count;
    logic [LFSR_W-1:0]   r_lfsr;
    logic [POLICY_W-1:0] r_policy;
    logic                r_op;
    logic [TAG_W-1:0]    r_val;
    logic [CW-1:0]       r_pos;
    logic [CW-1:0]       r_evict;
    logic [TAG_W-1:0]    r_tag;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [TAG_W-1:0]    r_tag_out;
    logic [CW-1:0]       r_occ;
    logic                r_last;

    logic [IW-1:0]       w_raddr;
    logic [IW-1:0]       w_waddr;
    logic [TAG_W-1:0]    w_wdata;
    logic [CW-1:0]       w_pos_next;
    logic [TAG_W-1:0]    n_tag_out;
    logic [CW-1:0]       n_occ;
    logic                w_rem_done;
    logic [CW-1:0]       w_rem;
    logic                w_out_free;

    function automatic logic [IW-1:0] f_slot(input logic [IW-1:0] head,
                                              input logic [CW-1:0] logical);
        logic [CW:0] s;
        s = (CW + 1)'(head) + (CW + 1)'(logical);
        if (s >= (CW + 1)'(CAPACITY)) begin
            s = s - (CW + 1)'(CAPACITY);
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [LFSR_W-1:0] f_lfsr_next(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] t;
        t = s >> 1;
        if (s[0]) begin
            t = t ^ LFSR_MASK;
        end
        return t;
    endfunction

    assign w_pos_next = r_pos + CW'(1);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (i_cmd.ra_sel)
            RA_POS:  w_raddr = f_slot(r_head, r_pos);
            RA_NEXT: w_raddr = f_slot(r_head, w_pos_next);
            default: w_raddr = r_head;
        endcase
        if (i_cmd.wa_sel == WA_POS) begin
            w_waddr = f_slot(r_head, r_pos);
            w_wdata = r_rdata;
        end else begin
            w_waddr = f_slot(r_head, r_count);
            w_wdata = r_val;
        end
        case (i_cmd.tag_sel)
            TAG_VAL:   n_tag_out = r_val;
            TAG_RDATA: n_tag_out = r_rdata;
            TAG_HOLD:  n_tag_out = r_tag;
            default:   n_tag_out = '0;
        endcase
        case (i_cmd.occ_sel)
            OCC_INC: n_occ = r_count + CW'(1);
            OCC_DEC: n_occ = r_count - CW'(1);
            default: n_occ = r_count;
        endcase
    end

    // tag ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    ofp_rem #(
        .VW (CW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.rem_start),
        .i_dividend (r_lfsr),
        .i_divisor  (r_count),
        .o_done     (w_rem_done),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_lfsr      <= LFSR_RESET;
            r_policy    <= POL_BLOCK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == CFG_POLICY) begin
                r_policy <= i_cfg_data[POLICY_W-1:0];
            end
            if (i_cfg_valid && i_cfg_index == CFG_SEED) begin
                // zero would lock the LFSR
                r_lfsr <= (i_cfg_data == '0) ? LFSR_RESET : i_cfg_data[LFSR_W-1:0];
            end else if (i_cmd.lfsr_adv) begin
                r_lfsr <= f_lfsr_next(r_lfsr);
            end
            if (i_cmd.head_inc) begin
                r_head <= (r_head == IW'(CAPACITY - 1)) ? '0 : r_head + IW'(1);
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op  <= i_operation;
            r_val <= i_entry_value;
        end
        if (i_cmd.pos_load) begin
            r_pos <= w_rem;
        end else if (i_cmd.pos_inc) begin
            r_pos <= w_pos_next;
        end
        if (i_cmd.evict_load) begin
            r_evict <= r_count >> 2;
        end else if (i_cmd.evict_dec) begin
            r_evict <= r_evict - CW'(1);
        end
        if (i_cmd.tag_hold) begin
            r_tag <= r_rdata;
        end
        if (i_cmd.emit) begin
            r_status  <= i_cmd.emit_status;
            r_tag_out <= n_tag_out;
            r_occ     <= n_occ;
            r_last    <= i_cmd.emit_last;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.empty      = (r_count == '0);
        o_stat.full       = (r_count == CW'(CAPACITY));
        o_stat.policy     = r_policy;
        o_stat.out_free   = w_out_free;
        o_stat.rem_done   = w_rem_done;
        o_stat.shift_more = ((CW + 1)'(r_pos) + (CW + 1)'(1)) < (CW + 1)'(r_count);
        o_stat.evict_last = (r_evict == CW'(1));
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_tag_out   = r_tag_out;
    assign o_occupancy = r_occ;
    assign o_last      = r_last;

endmodule
